/* rtl/core/cslarb_pkg.sv */
// Shared codes and types for the command source lease arbiter.
`timescale 1ns / 1ps

package cslarb_pkg;

  // Function codes on the request channel
  localparam logic [2:0] FUNC_SUBMIT  = 3'd0;
  localparam logic [2:0] FUNC_DISC    = 3'd1;
  localparam logic [2:0] FUNC_DISARM  = 3'd2;
  localparam logic [2:0] FUNC_ESTOP   = 3'd3;
  localparam logic [2:0] FUNC_RESOLVE = 3'd4;

  // Decoded operation kinds handed from front to back
  localparam logic [2:0] OP_SUBMIT  = 3'd0;
  localparam logic [2:0] OP_DISC    = 3'd1;
  localparam logic [2:0] OP_DISARM  = 3'd2;
  localparam logic [2:0] OP_ESTOP   = 3'd3;
  localparam logic [2:0] OP_RESOLVE = 3'd4;
  localparam logic [2:0] OP_NOP     = 3'd5;

  // Command sources
  localparam logic [1:0] SRC_NONE   = 2'd0;
  localparam logic [1:0] SRC_SERIAL = 2'd1;
  localparam logic [1:0] SRC_WEB    = 2'd2;
  localparam logic [1:0] SRC_LOCAL  = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  src;
    logic [31:0] seq;
    logic        estop;
    logic        disarm;
    logic [63:0] lease;
    logic [31:0] body;
    logic        level;
    logic [63:0] now;
  } op_t;

  typedef struct packed {
    logic        is_command;
    logic [1:0]  out_source;
    logic [31:0] out_sequence;
    logic        out_estop;
    logic        out_disarm;
    logic [63:0] out_lease_end;
    logic [31:0] out_payload;
    logic [1:0]  owner;
  } rsp_t;

endpackage

/* rtl/core/cslarb_if.sv */
// Request and response channel interfaces of the command source lease arbiter.
`timescale 1ns / 1ps

interface cslarb_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [1:0]  cmd_source;
  logic [31:0] cmd_sequence;
  logic        cmd_estop;
  logic        cmd_disarm;
  logic [63:0] cmd_lease_end;
  logic [31:0] cmd_payload;
  logic        level;
  logic [63:0] now_time;

  modport source (
    output valid, func, cmd_source, cmd_sequence, cmd_estop, cmd_disarm,
           cmd_lease_end, cmd_payload, level, now_time,
    input  ready
  );
  modport sink (
    input  valid, func, cmd_source, cmd_sequence, cmd_estop, cmd_disarm,
           cmd_lease_end, cmd_payload, level, now_time,
    output ready
  );
endinterface

interface cslarb_rsp_if;
  logic        valid;
  logic        ready;
  logic        is_command;
  logic [1:0]  out_source;
  logic [31:0] out_sequence;
  logic        out_estop;
  logic        out_disarm;
  logic [63:0] out_lease_end;
  logic [31:0] out_payload;
  logic [1:0]  owner;

  modport source (
    output valid, is_command, out_source, out_sequence, out_estop, out_disarm,
           out_lease_end, out_payload, owner,
    input  ready
  );
  modport sink (
    input  valid, is_command, out_source, out_sequence, out_estop, out_disarm,
           out_lease_end, out_payload, owner,
    output ready
  );
endinterface

/* rtl/core/cslarb_front.sv */
// Front stage: accepts request beats, decodes the function and registers the operation.
`timescale 1ns / 1ps

module cslarb_front (
  input  logic              clk,
  input  logic              rst,
  cslarb_req_if.sink        req,
  output logic              op_valid,
  input  logic              op_ready,
  output cslarb_pkg::op_t   op
);

  logic            valid;
  cslarb_pkg::op_t op_next;

  assign req.ready = !valid || op_ready;
  assign op_valid  = valid;

  always_comb begin
    op_next        = '0;
    op_next.src    = req.cmd_source;
    op_next.seq    = req.cmd_sequence;
    op_next.estop  = req.cmd_estop;
    op_next.disarm = req.cmd_disarm;
    op_next.lease  = req.cmd_lease_end;
    op_next.body   = req.cmd_payload;
    op_next.level  = req.level;
    op_next.now    = req.now_time;
    case (req.func)
      cslarb_pkg::FUNC_SUBMIT:  op_next.kind = cslarb_pkg::OP_SUBMIT;
      cslarb_pkg::FUNC_DISC:    op_next.kind = cslarb_pkg::OP_DISC;
      cslarb_pkg::FUNC_DISARM:  op_next.kind = cslarb_pkg::OP_DISARM;
      cslarb_pkg::FUNC_ESTOP:   op_next.kind = cslarb_pkg::OP_ESTOP;
      cslarb_pkg::FUNC_RESOLVE: op_next.kind = cslarb_pkg::OP_RESOLVE;
      default:                  op_next.kind = cslarb_pkg::OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (req.ready) begin
      valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op <= op_next;
    end
  end

endmodule

/* rtl/core/cslarb_queue.sv */
// Small register queue between the decode front and the execute back.
`timescale 1ns / 1ps

module cslarb_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != FULL);
  assign out_valid = (count != '0);
  assign out_data  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

endmodule

/* rtl/core/cslarb_back.sv */
// Execute stage: holds ownership, latches and source slots, produces one response per operation.
`timescale 1ns / 1ps

module cslarb_back #(
  parameter int SEQ_BITS     = 32,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            op_valid,
  output logic            op_ready,
  input  cslarb_pkg::op_t op,
  cslarb_rsp_if.source    rsp
);

  localparam int SEQ_W = (SEQ_BITS < 32) ? SEQ_BITS : 32;
  localparam int PAY_W = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;

  logic [1:0]       owner,      owner_next;
  logic             s_pend,     s_pend_next;
  logic             w_pend,     w_pend_next;
  logic             s_seen,     s_seen_next;
  logic             w_seen,     w_seen_next;
  logic             disarm_lat, disarm_lat_next;
  logic             estop_lat,  estop_lat_next;
  logic [3:0]       s_tag,      s_tag_next;
  logic [SEQ_W-1:0] s_seq,      s_seq_next;
  logic [63:0]      s_lease,    s_lease_next;
  logic [PAY_W-1:0] s_body,     s_body_next;
  logic [3:0]       w_tag,      w_tag_next;
  logic [SEQ_W-1:0] w_seq,      w_seq_next;
  logic [63:0]      w_lease,    w_lease_next;
  logic [PAY_W-1:0] w_body,     w_body_next;

  logic                 out_valid;
  cslarb_pkg::rsp_t     out_beat;
  cslarb_pkg::rsp_t     res;
  logic                 fire;
  logic [SEQ_W-1:0]     in_seq;
  logic [PAY_W-1:0]     in_body;
  logic [3:0]           in_tag;
  logic                 s_live;
  logic                 w_live;
  logic                 granted;
  cslarb_pkg::rsp_t     s_view;
  cslarb_pkg::rsp_t     w_view;

  assign op_ready = !out_valid || rsp.ready;
  assign fire     = op_valid && op_ready;

  assign in_seq  = op.seq[SEQ_W-1:0];
  assign in_body = op.body[PAY_W-1:0];
  assign in_tag  = {op.disarm, op.estop, op.src};

  assign s_live = (s_tag[1:0] != cslarb_pkg::SRC_NONE) && (s_lease >= op.now);
  assign w_live = (w_tag[1:0] != cslarb_pkg::SRC_NONE) && (w_lease >= op.now);

  // Slot contents as a resolved command
  always_comb begin
    s_view               = '0;
    s_view.is_command    = 1'b1;
    s_view.out_source    = s_tag[1:0];
    s_view.out_estop     = s_tag[2];
    s_view.out_disarm    = s_tag[3];
    s_view.out_sequence  = 32'(s_seq);
    s_view.out_lease_end = s_lease;
    s_view.out_payload   = 32'(s_body);
    w_view               = '0;
    w_view.is_command    = 1'b1;
    w_view.out_source    = w_tag[1:0];
    w_view.out_estop     = w_tag[2];
    w_view.out_disarm    = w_tag[3];
    w_view.out_sequence  = 32'(w_seq);
    w_view.out_lease_end = w_lease;
    w_view.out_payload   = 32'(w_body);
  end

  always_comb begin
    owner_next      = owner;
    s_pend_next     = s_pend;
    w_pend_next     = w_pend;
    s_seen_next     = s_seen;
    w_seen_next     = w_seen;
    disarm_lat_next = disarm_lat;
    estop_lat_next  = estop_lat;
    s_tag_next      = s_tag;
    s_seq_next      = s_seq;
    s_lease_next    = s_lease;
    s_body_next     = s_body;
    w_tag_next      = w_tag;
    w_seq_next      = w_seq;
    w_lease_next    = w_lease;
    w_body_next     = w_body;
    res             = '0;
    granted         = 1'b0;

    case (op.kind)
      cslarb_pkg::OP_SUBMIT: begin
        // Estop request or serial preempting web drops ownership
        if (op.estop || (op.src == cslarb_pkg::SRC_SERIAL && owner == cslarb_pkg::SRC_WEB)) begin
          owner_next  = cslarb_pkg::SRC_NONE;
          s_pend_next = 1'b0;
          w_pend_next = 1'b0;
        end
        if (op.src == cslarb_pkg::SRC_SERIAL && !(s_seen && in_seq == s_seq)) begin
          s_tag_next   = in_tag;
          s_seq_next   = in_seq;
          s_lease_next = op.lease;
          s_body_next  = in_body;
          s_seen_next  = 1'b1;
          s_pend_next  = 1'b1;
        end else if (op.src == cslarb_pkg::SRC_WEB && !(w_seen && in_seq == w_seq)) begin
          w_tag_next   = in_tag;
          w_seq_next   = in_seq;
          w_lease_next = op.lease;
          w_body_next  = in_body;
          w_seen_next  = 1'b1;
          w_pend_next  = (owner_next != cslarb_pkg::SRC_SERIAL);
        end
      end
      cslarb_pkg::OP_DISC: begin
        // Clear the slot but keep the seen mark
        if (op.src == cslarb_pkg::SRC_SERIAL) begin
          s_tag_next   = '0;
          s_seq_next   = '0;
          s_lease_next = '0;
          s_body_next  = '0;
          s_pend_next  = 1'b0;
        end else if (op.src == cslarb_pkg::SRC_WEB) begin
          w_tag_next   = '0;
          w_seq_next   = '0;
          w_lease_next = '0;
          w_body_next  = '0;
          w_pend_next  = 1'b0;
        end
        if (owner == op.src) begin
          owner_next  = cslarb_pkg::SRC_NONE;
          s_pend_next = 1'b0;
          w_pend_next = 1'b0;
        end
      end
      cslarb_pkg::OP_DISARM: begin
        if (op.level && !disarm_lat) begin
          owner_next  = cslarb_pkg::SRC_NONE;
          s_pend_next = 1'b0;
          w_pend_next = 1'b0;
        end
        disarm_lat_next = op.level;
      end
      cslarb_pkg::OP_ESTOP: begin
        if (op.level && !estop_lat) begin
          owner_next  = cslarb_pkg::SRC_NONE;
          s_pend_next = 1'b0;
          w_pend_next = 1'b0;
        end
        estop_lat_next = op.level;
      end
      cslarb_pkg::OP_RESOLVE: begin
        res.is_command = 1'b1;
        if (estop_lat) begin
          res.out_source = cslarb_pkg::SRC_LOCAL;
          res.out_estop  = 1'b1;
          res.out_disarm = 1'b1;
        end else if (disarm_lat) begin
          res.out_source = cslarb_pkg::SRC_LOCAL;
          res.out_disarm = 1'b1;
        end else if (owner == cslarb_pkg::SRC_SERIAL) begin
          if (s_live) begin
            res = s_view;
          end else begin
            owner_next  = cslarb_pkg::SRC_NONE;
            s_pend_next = 1'b0;
            w_pend_next = 1'b0;
          end
        end else if (owner == cslarb_pkg::SRC_WEB) begin
          if (w_live) begin
            res = w_view;
          end else begin
            owner_next  = cslarb_pkg::SRC_NONE;
            s_pend_next = 1'b0;
            w_pend_next = 1'b0;
          end
        end else begin
          // No owner: serial pending wins, a serial claim also drops web pending
          if (s_pend) begin
            s_pend_next = 1'b0;
            w_pend_next = 1'b0;
            if (s_live) begin
              owner_next = cslarb_pkg::SRC_SERIAL;
              res        = s_view;
              granted    = 1'b1;
            end
          end
          if (!granted && w_pend_next) begin
            w_pend_next = 1'b0;
            if (w_live) begin
              owner_next = cslarb_pkg::SRC_WEB;
              res        = w_view;
            end
          end
        end
      end
      default: begin
      end
    endcase

    res.owner = owner_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owner      <= cslarb_pkg::SRC_NONE;
      s_pend     <= 1'b0;
      w_pend     <= 1'b0;
      s_seen     <= 1'b0;
      w_seen     <= 1'b0;
      disarm_lat <= 1'b0;
      estop_lat  <= 1'b0;
      s_tag      <= '0;
      s_seq      <= '0;
      s_lease    <= '0;
      s_body     <= '0;
      w_tag      <= '0;
      w_seq      <= '0;
      w_lease    <= '0;
      w_body     <= '0;
    end else if (fire) begin
      owner      <= owner_next;
      s_pend     <= s_pend_next;
      w_pend     <= w_pend_next;
      s_seen     <= s_seen_next;
      w_seen     <= w_seen_next;
      disarm_lat <= disarm_lat_next;
      estop_lat  <= estop_lat_next;
      s_tag      <= s_tag_next;
      s_seq      <= s_seq_next;
      s_lease    <= s_lease_next;
      s_body     <= s_body_next;
      w_tag      <= w_tag_next;
      w_seq      <= w_seq_next;
      w_lease    <= w_lease_next;
      w_body     <= w_body_next;
    end
  end

  // Output register: hold the beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op_ready) begin
      out_valid <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_beat <= res;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.is_command    = out_beat.is_command;
  assign rsp.out_source    = out_beat.out_source;
  assign rsp.out_sequence  = out_beat.out_sequence;
  assign rsp.out_estop     = out_beat.out_estop;
  assign rsp.out_disarm    = out_beat.out_disarm;
  assign rsp.out_lease_end = out_beat.out_lease_end;
  assign rsp.out_payload   = out_beat.out_payload;
  assign rsp.owner         = out_beat.owner;

endmodule

/* rtl/core/command_source_lease_arbiter_unit.sv */
// Top level of the command source lease arbiter: front decode, queue, execute back.
//
//   Channel  Dir  Beat contents
//   req      in   func, source, sequence, estop, disarm, lease end, payload, level, now
//   rsp      out  is_command, source, sequence, estop, disarm, lease end, payload, owner
//
// One request beat per cycle is taken while the queue has room, and each
// gives exactly one response beat. A request passes the decode register,
// a queue entry and then the execute step, which loads the output register.
// Reset clears ownership, latches, pending and seen marks and both source slots.
// A two-entry queue separates decode from execute; the output register is
// reloaded in the same cycle its beat is taken, so rsp stalls back up only
// when the queue fills.
`timescale 1ns / 1ps

module command_source_lease_arbiter_unit #(
  parameter int SEQ_BITS     = 32,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  cslarb_req_if.sink   req,
  cslarb_rsp_if.source rsp
);

  localparam int OP_W = $bits(cslarb_pkg::op_t);

  logic            dec_valid;
  logic            dec_ready;
  cslarb_pkg::op_t dec_op;
  logic            head_valid;
  logic            head_ready;
  logic [OP_W-1:0] head_data;
  cslarb_pkg::op_t head_op;

  assign head_op = cslarb_pkg::op_t'(head_data);

  cslarb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .op_valid (dec_valid),
    .op_ready (dec_ready),
    .op       (dec_op)
  );

  cslarb_queue #(
    .WIDTH (OP_W),
    .DEPTH (2)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .in_data   (OP_W'(dec_op)),
    .out_valid (head_valid),
    .out_ready (head_ready),
    .out_data  (head_data)
  );

  cslarb_back #(
    .SEQ_BITS     (SEQ_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (head_valid),
    .op_ready (head_ready),
    .op       (head_op),
    .rsp      (rsp)
  );

endmodule
